@@ hdl/assert_macros.svh @@
// assertion helpers on clk; only ASSERT_CLK is off in rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ hdl/lruct_pkg.sv @@
package lruct_pkg;

  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

@@ hdl/lruct_tag_store.sv @@
`include "assert_macros.svh"

module lruct_tag_store #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       update,
  input  logic [KEY_BITS-1:0]        key,
  input  logic [lruct_pkg::CAP_W-1:0] capacity,
  output logic                       hit
);
  import lruct_pkg::*;

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ECAP_W = $clog2(ENTRIES + 1);
  localparam int WIDE_W = CAP_W + ECAP_W;

  logic [KEY_BITS-1:0] keys [ENTRIES];
  logic [ENTRIES-1:0]  valid;
  logic [RANK_W-1:0]   rank [ENTRIES];

  logic [ENTRIES-1:0]  valid_next;
  logic [RANK_W-1:0]   rank_next [ENTRIES];

  logic [ENTRIES-1:0]  match;
  logic [ENTRIES-1:0]  evict;
  logic [ENTRIES-1:0]  kept;
  logic [ENTRIES-1:0]  free_vec;
  logic [ENTRIES-1:0]  free_oh;
  logic [ENTRIES-1:0]  rank_zero;
  logic [RANK_W-1:0]   hit_rank;
  logic [WIDE_W-1:0]   cap_wide;
  logic [WIDE_W-1:0]   eff_cap;
  logic [WIDE_W-1:0]   keep_wide;
  logic [RANK_W-1:0]   keep;

  // effective capacity: zero acts as one, saturate at entry count
  always_comb begin
    cap_wide = WIDE_W'(capacity);
    if (cap_wide == '0) begin
      eff_cap = WIDE_W'(1);
    end else if (cap_wide > WIDE_W'(ENTRIES)) begin
      eff_cap = WIDE_W'(ENTRIES);
    end else begin
      eff_cap = cap_wide;
    end
    keep_wide = eff_cap - WIDE_W'(1);
    keep      = keep_wide[RANK_W-1:0];
  end

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]     = valid[i] && (keys[i] == key);
      evict[i]     = valid[i] && (rank[i] >= keep);
      rank_zero[i] = valid[i] && (rank[i] == '0);
      hit_rank     = hit_rank | (match[i] ? rank[i] : '0);
    end
    hit      = |match;
    kept     = valid & ~evict;
    free_vec = ~kept;
    free_oh  = free_vec & (~free_vec + ENTRIES'(1));
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit) begin
        valid_next[i] = valid[i];
        if (match[i]) begin
          rank_next[i] = '0;
        end else if (valid[i] && (rank[i] < hit_rank)) begin
          rank_next[i] = rank[i] + RANK_W'(1);
        end else begin
          rank_next[i] = rank[i];
        end
      end else begin
        valid_next[i] = kept[i] | free_oh[i];
        if (free_oh[i]) begin
          rank_next[i] = '0;
        end else if (kept[i]) begin
          rank_next[i] = rank[i] + RANK_W'(1);
        end else begin
          rank_next[i] = rank[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (update) begin
      valid <= valid_next;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (update && !hit && free_oh[i]) begin
        keys[i] <= key;
      end
    end
  end

  `ASSERT_CLK(a_miss_fits_cap, update && !hit |=> $countones(valid) <= $past(eff_cap), "miss left more entries than capacity")
  `ASSERT_CLK(a_hit_keeps_fill, update && hit |=> $countones(valid) == $past($countones(valid)), "hit changed entry count")
  `ASSERT_CLK(a_one_mru, update |=> $countones(rank_zero) == 1, "most recent entry not unique")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> valid == '0, "entries not cleared by reset")

endmodule

@@ hdl/lru_cache_hit_tracker_core.sv @@
// Fully associative LRU tag tracker. Each request on the slave stream is a key; one
// result per request comes out on the master stream with tdata[0] = 1 on a hit. A hit
// makes the key most recent; a miss evicts every entry ranked at or beyond capacity-1
// and inserts the key as most recent. One request is taken every cycle while m_tready is
// high; a request passes an input register and then the parallel tag compare and rank
// update over all ENTRIES slots, which ends in the result register. Capacity zero acts as
// one, values above ENTRIES act as ENTRIES; lowering it takes effect on the next miss.
// Entries are empty after reset.
`include "assert_macros.svh"

module lru_cache_hit_tracker_core #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 16,
  localparam int TDATA_W = ((KEY_BITS + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lruct_pkg::CAP_W-1:0] cfg_wdata,   // capacity
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [TDATA_W-1:0]          s_tdata,     // key
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata      // hit
);
  import lruct_pkg::*;

  logic [CAP_W-1:0]    capacity;
  logic                in_valid;
  logic [KEY_BITS-1:0] in_key;
  logic                out_valid;
  logic                out_hit;
  logic                advance;
  logic                hit;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_key <= s_tdata[KEY_BITS-1:0];
    end
    if (advance) begin
      out_hit <= hit;
    end
  end

  lruct_tag_store #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS)
  ) u_tags (
    .clk      (clk),
    .rst      (rst),
    .update   (advance),
    .key      (in_key),
    .capacity (capacity),
    .hit      (hit)
  );

  `ASSERT_CLK(a_stage_held, in_valid && !advance |=> in_valid && $stable(in_key), "pending request dropped")
  `ASSERT_CLK(a_result_loaded, advance |=> out_valid && out_hit == $past(hit), "result register not loaded")
  `ASSERT_CLK(a_no_overwrite, out_valid && !m_tready |-> !advance, "result overwritten while stalled")

endmodule

@@ verif/lru_cache_hit_tracker_core_tb.sv @@
`timescale 1ns / 1ps

module lru_cache_hit_tracker_core_tb;
  import lruct_pkg::*;

  localparam int SLOTS       = 16;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 14;
  localparam int PHASE_LEN   = 100;
  localparam int PROBE_ROWS  = 25;

  typedef enum logic {ROW_KEY, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {WANT_MISS, WANT_HIT, WANT_MODEL} want_t;
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    want_t       want;
  } probe_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [15:0]      s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [7:0]       m_tdata;

  // lru state kept alongside the block
  logic [15:0]      key_tag [SLOTS];
  bit               tag_valid [SLOTS];
  int               recency [SLOTS];
  logic [CAP_W-1:0] cap_reg;

  logic   pending_hits [$];
  want_t  want_sel;
  bit     no_gaps;
  int     rx_hold;
  int     idle_run;
  int     errors;

  probe_row_t probes [PROBE_ROWS] = '{
    '{ROW_KEY, 16'h0000, WANT_MISS},
    '{ROW_KEY, 16'h0000, WANT_HIT},
    '{ROW_KEY, 16'hFFFF, WANT_MISS},
    '{ROW_KEY, 16'hFFFF, WANT_HIT},
    '{ROW_KEY, 16'h0000, WANT_HIT},
    '{ROW_CFG, 16'd1,    WANT_MODEL},
    '{ROW_KEY, 16'hFFFF, WANT_HIT},
    '{ROW_KEY, 16'h1234, WANT_MISS},
    '{ROW_KEY, 16'hFFFF, WANT_MISS},
    '{ROW_KEY, 16'h1234, WANT_MISS},
    '{ROW_CFG, 16'd0,    WANT_MODEL},
    '{ROW_KEY, 16'h1234, WANT_HIT},
    '{ROW_KEY, 16'h5555, WANT_MISS},
    '{ROW_KEY, 16'h1234, WANT_MISS},
    '{ROW_CFG, 16'd31,   WANT_MODEL},
    '{ROW_KEY, 16'hAAAA, WANT_MISS},
    '{ROW_KEY, 16'h1234, WANT_HIT},
    '{ROW_CFG, 16'd2,    WANT_MODEL},
    '{ROW_KEY, 16'h0100, WANT_MODEL},
    '{ROW_KEY, 16'h0200, WANT_MODEL},
    '{ROW_KEY, 16'h0100, WANT_MODEL},
    '{ROW_KEY, 16'h0300, WANT_MODEL},
    '{ROW_KEY, 16'h0200, WANT_MODEL},
    '{ROW_CFG, 16'd16,   WANT_MODEL},
    '{ROW_KEY, 16'h0300, WANT_MODEL}
  };

  lru_cache_hit_tracker_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic lru_touch(input logic [15:0] k);
    int slot;
    int open_slot;
    int age;
    int keep;
    slot = -1;
    open_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_valid[i] && key_tag[i] == k && slot < 0) slot = i;
    end
    if (slot >= 0) begin
      age = recency[slot];
      for (int i = 0; i < SLOTS; i++) begin
        if (tag_valid[i] && recency[i] < age) recency[i]++;
      end
      recency[slot] = 0;
      return 1'b1;
    end
    if (cap_reg == 0) keep = 0;
    else if (cap_reg > SLOTS) keep = SLOTS - 1;
    else keep = cap_reg - 1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_valid[i] && recency[i] >= keep) tag_valid[i] = 1'b0;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_valid[i]) recency[i]++;
      else if (open_slot < 0) open_slot = i;
    end
    if (open_slot >= 0) begin
      key_tag[open_slot] = k;
      tag_valid[open_slot] = 1'b1;
      recency[open_slot] = 0;
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] exp_v);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, exp_v);
    errors++;
  endtask

  always @(posedge clk) begin : scoreboard
    logic h;
    logic want_hit;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tag_valid[i] = 1'b0;
        recency[i] = 0;
      end
      cap_reg = CAP_RESET;
      idle_run = 0;
    end else begin
      if (cfg_we) cap_reg = cfg_wdata;
      if (s_tvalid && s_tready) begin
        h = lru_touch(s_tdata);
        if (want_sel == WANT_MODEL) pending_hits = {pending_hits, h};
        else pending_hits = {pending_hits, (want_sel == WANT_HIT)};
      end
      if (m_tvalid && m_tready) begin
        if (pending_hits.size() == 0) begin
          flag_mismatch("unexpected hit flag", m_tdata, 8'h00);
        end else begin
          want_hit = pending_hits[0];
          pending_hits.delete(0);
          if (m_tdata !== {7'b0, want_hit}) flag_mismatch("hit flag", m_tdata, {7'b0, want_hit});
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) idle_run = 0;
      else idle_run++;
    end
  end

  initial begin : watchdog
    wait (rst === 1'b0);
    while (idle_run < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // result side: random stall per result unless no_gaps is set, plus a one-off long hold when asked
  initial begin : result_sink
    int stall;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = (no_gaps ? 0 : $urandom_range(0, 16)) + rx_hold;
      rx_hold = 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_key(input logic [15:0] k, input want_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    want_sel = w;
    s_tvalid <= 1'b1;
    s_tdata  <= k;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0]      key_pool [32];
    int               pool_size;
    int               pick;
    logic [CAP_W-1:0] cap_v;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    want_sel  = WANT_MODEL;
    no_gaps   = 1'b0;
    rx_hold   = 0;
    errors    = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (probes[r]) begin
      if (probes[r].kind == ROW_CFG) write_capacity(probes[r].value[CAP_W-1:0]);
      else send_key(probes[r].value, probes[r].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) cap_v = 5'd1;
      else if (ph == 1) cap_v = 5'd16;
      else begin
        pick = $urandom_range(0, 19);
        if (pick < 16) cap_v = CAP_W'(pick + 1);
        else if (pick == 16) cap_v = 5'd0;
        else if (pick == 17) cap_v = 5'd31;
        else cap_v = CAP_W'($urandom_range(17, 30));
      end
      write_capacity(cap_v);
      no_gaps = (ph % 4 == 3);
      if (ph == 5) rx_hold = 120;
      pool_size = $urandom_range(2, 24);
      for (int i = 0; i < pool_size; i++) key_pool[i] = 16'($urandom_range(0, 16'hFFFF));
      for (int n = 0; n < PHASE_LEN; n++) begin
        if ($urandom_range(0, 9) == 0) send_key(16'($urandom_range(0, 16'hFFFF)), WANT_MODEL);
        else send_key(key_pool[$urandom_range(0, pool_size - 1)], WANT_MODEL);
      end
    end

    no_gaps = 1'b0;
    settle();
    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ lru_cache_hit_tracker_core.f @@
+incdir+hdl
hdl/lruct_pkg.sv
hdl/lruct_tag_store.sv
hdl/lru_cache_hit_tracker_core.sv
verif/lru_cache_hit_tracker_core_tb.sv
